FILE: sv/assert_macros.svh
// ---------------------------------------------------------------------------
// assertion macros
// short forms for clocked implication checks with asynchronous reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, consequent may carry a fixed delay
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error("implication check failed");

// next-cycle implication
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
        else $error("next-cycle check failed");

`endif

FILE: sv/thc_pkg.sv
// ---------------------------------------------------------------------------
// thc_pkg
// shared types and constants of the temperature / humidity compensation core
// ---------------------------------------------------------------------------
`default_nettype none

package thc_pkg;

    localparam int THC_ADDR_W = 5;
    localparam int THC_DATA_W = 32;

    typedef enum logic [2:0] {
        REG_CAL_T1    = 3'd0,
        REG_CAL_T2    = 3'd1,
        REG_CAL_T3    = 3'd2,
        REG_CAL_H1    = 3'd3,
        REG_CAL_H2    = 3'd4,
        REG_CAL_H3_H6 = 3'd5,
        REG_CAL_H4    = 3'd6,
        REG_CAL_H5    = 3'd7
    } thc_reg_idx_t;

    typedef struct packed {
        logic        [15:0] t1;
        logic signed [15:0] t2;
        logic signed [15:0] t3;
        logic        [7:0]  h1;
        logic signed [15:0] h2;
        logic        [15:0] h3_h6;
        logic        [11:0] h4;
        logic        [11:0] h5;
    } thc_cal_t;

    // reciprocal of 100, exact for magnitudes up to 2^23, shift of 30
    localparam logic [23:0] THC_DIV100_MUL   = 24'd10737419;
    localparam int          THC_DIV100_SHIFT = 30;

    localparam logic signed [31:0] THC_HUM_CLAMP_MAX = 32'sd419430400;

endpackage

`default_nettype wire

FILE: sv/thc_regs.sv
// ---------------------------------------------------------------------------
// thc_regs
// calibration register bank behind a simple bus slave port
// ---------------------------------------------------------------------------
`default_nettype none

module thc_regs
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [thc_pkg::THC_ADDR_W-1:0] paddr,
    input  wire logic [thc_pkg::THC_DATA_W-1:0] pwdata,
    output logic      [thc_pkg::THC_DATA_W-1:0] prdata,
    output logic                                pready,
    output thc_pkg::thc_cal_t                   cal
);

    thc_pkg::thc_cal_t     cal_reg;
    thc_pkg::thc_reg_idx_t idx;
    logic                  wr_en;

    assign idx    = thc_pkg::thc_reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cal    = cal_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_reg <= '0;
        end
        else if (wr_en)
        begin
            case (idx)
                thc_pkg::REG_CAL_T1:    cal_reg.t1    <= pwdata[15:0];
                thc_pkg::REG_CAL_T2:    cal_reg.t2    <= pwdata[15:0];
                thc_pkg::REG_CAL_T3:    cal_reg.t3    <= pwdata[15:0];
                thc_pkg::REG_CAL_H1:    cal_reg.h1    <= pwdata[7:0];
                thc_pkg::REG_CAL_H2:    cal_reg.h2    <= pwdata[15:0];
                thc_pkg::REG_CAL_H3_H6: cal_reg.h3_h6 <= pwdata[15:0];
                thc_pkg::REG_CAL_H4:    cal_reg.h4    <= pwdata[11:0];
                thc_pkg::REG_CAL_H5:    cal_reg.h5    <= pwdata[11:0];
                default:                cal_reg       <= cal_reg;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            thc_pkg::REG_CAL_T1:    prdata = {16'd0, cal_reg.t1};
            thc_pkg::REG_CAL_T2:    prdata = {16'd0, cal_reg.t2};
            thc_pkg::REG_CAL_T3:    prdata = {16'd0, cal_reg.t3};
            thc_pkg::REG_CAL_H1:    prdata = {24'd0, cal_reg.h1};
            thc_pkg::REG_CAL_H2:    prdata = {16'd0, cal_reg.h2};
            thc_pkg::REG_CAL_H3_H6: prdata = {16'd0, cal_reg.h3_h6};
            thc_pkg::REG_CAL_H4:    prdata = {20'd0, cal_reg.h4};
            thc_pkg::REG_CAL_H5:    prdata = {20'd0, cal_reg.h5};
            default:                prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

FILE: sv/temp_humidity_compensation_core.sv
// ---------------------------------------------------------------------------
// temp_humidity_compensation_core
// ten-stage integer compensation of raw temperature and humidity readings
// ---------------------------------------------------------------------------
// One item is taken in every clock cycle: busy stays low, so start alone
// marks an item. Each result appears on the output ports for a single cycle
// with done high; the receiver cannot hold results off and must take them
// as they come. Latency is set by the chain of eight dependent 32x32
// multiplications from the raw temperature through the humidity path,
// at most one per register stage. The user must write calibration registers
// over the bus port only while no item is in flight; nothing enforces it.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module temp_humidity_compensation_core
(
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [19:0]                    raw_temperature,
    input  wire logic [15:0]                    raw_humidity,
    output logic                                done,
    output logic signed [31:0]                  fine_temperature,
    output logic signed [23:0]                  temperature_centi,
    output logic signed [17:0]                  temperature_whole,
    output logic signed [7:0]                   temperature_hundredths,
    output logic        [16:0]                  humidity_q10,
    output logic        [6:0]                   humidity_whole,
    output logic        [9:0]                   humidity_fraction,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [thc_pkg::THC_ADDR_W-1:0] paddr,
    input  wire logic [thc_pkg::THC_DATA_W-1:0] pwdata,
    output logic      [thc_pkg::THC_DATA_W-1:0] prdata,
    output logic                                pready
);

    typedef struct packed {
        logic signed [31:0] fine;
        logic signed [23:0] tc;
        logic signed [17:0] tw;
        logic signed [7:0]  tr;
    } tpath_t;

    thc_pkg::thc_cal_t cal;

    thc_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cal     (cal)
    );

    // calibration words widened to 32 bits
    logic signed [31:0] t1_ext, t2_ext, t3_ext;
    logic signed [31:0] h1_ext, h2_ext, h3_ext, h4_sh, h5_ext, h6_ext;

    assign t1_ext = $signed({16'd0, cal.t1});
    assign t2_ext = 32'(cal.t2);
    assign t3_ext = 32'(cal.t3);
    assign h1_ext = $signed({24'd0, cal.h1});
    assign h2_ext = 32'(cal.h2);
    assign h3_ext = $signed({24'd0, cal.h3_h6[7:0]});
    assign h4_sh  = $signed({cal.h4, 20'd0});
    assign h5_ext = $signed({20'd0, cal.h5});
    assign h6_ext = 32'($signed(cal.h3_h6[15:8]));

    logic accept;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    logic [10:1] vld_reg;

    // pipeline registers
    logic signed [31:0] p1_reg, dd_reg, v1_reg, p2_reg, fine_reg;
    logic signed [31:0] mh5_reg, mh6_reg, mh3_reg;
    logic signed [31:0] a5_reg, bc_reg, a6_reg, me_reg;
    logic signed [31:0] xx7_reg, xx8_reg, xx9_reg, ss_reg, gm_reg;
    logic        [15:0] rh_reg [1:4];
    logic        [23:0] mag5_reg;
    logic               neg5_reg;
    logic        [16:0] q5_reg;
    tpath_t             tp_reg [4:9];
    logic        [16:0] hum_reg;

    // next values
    logic signed [31:0] ta, td;
    logic signed [31:0] p1_next, dd_next, v1_next, p2_next, fine_next;
    logic signed [31:0] hx, tc_full;
    logic signed [31:0] mh5_next, mh6_next, mh3_next;
    logic signed [31:0] a5_next, bc_next, me_next, xx7_next, ss_next, gm_next;
    logic signed [31:0] hs, hdiff, hclamp;
    logic        [23:0] tc_mag;
    logic        [47:0] qprod;
    logic        [16:0] q5_next;
    logic        [23:0] qx100;
    logic        [6:0]  rem;
    logic signed [17:0] tw_next;
    logic signed [7:0]  tr_next;
    logic        [16:0] hum_next;

    always_comb
    begin
        // stage 1: temperature products straight from the ports
        ta      = $signed({15'd0, raw_temperature[19:3]}) - $signed({15'd0, cal.t1, 1'b0});
        td      = $signed({16'd0, raw_temperature[19:4]}) - t1_ext;
        p1_next = ta * t2_ext;
        dd_next = td * td;

        // stage 2
        v1_next = p1_reg >>> 11;
        p2_next = (dd_reg >>> 12) * t3_ext;

        // stage 3
        fine_next = v1_reg + (p2_reg >>> 14);

        // stage 4: centi-degrees and the three humidity products
        tc_full  = ((fine_reg <<< 2) + fine_reg + 32'sd128) >>> 8;
        hx       = fine_reg - 32'sd76800;
        mh5_next = h5_ext * hx;
        mh6_next = hx * h6_ext;
        mh3_next = hx * h3_ext;

        // stage 5
        a5_next = ($signed({2'd0, rh_reg[4], 14'd0}) - h4_sh - mh5_reg + 32'sd16384) >>> 15;
        bc_next = (mh6_reg >>> 10) * ((mh3_reg >>> 11) + 32'sd32768);
        tc_mag  = tp_reg[4].tc[23] ? (24'd0 - tp_reg[4].tc) : tp_reg[4].tc;
        qprod   = 48'(tc_mag) * 48'(thc_pkg::THC_DIV100_MUL);
        q5_next = qprod[thc_pkg::THC_DIV100_SHIFT +: 17];

        // stage 6: sign-of-dividend split
        me_next = ((bc_reg >>> 10) + 32'sd2097152) * h2_ext;
        qx100   = 24'(q5_reg) * 24'd100;
        rem     = 7'(mag5_reg - qx100);
        tw_next = neg5_reg ? (18'd0 - {1'b0, q5_reg}) : {1'b0, q5_reg};
        tr_next = neg5_reg ? (8'd0 - {1'b0, rem}) : {1'b0, rem};

        // stage 7
        xx7_next = a6_reg * ((me_reg + 32'sd8192) >>> 14);

        // stage 8
        hs      = xx7_reg >>> 15;
        ss_next = hs * hs;

        // stage 9
        gm_next = (ss_reg >>> 7) * h1_ext;

        // stage 10: saturation correction and clamp
        hdiff = xx9_reg - (gm_reg >>> 4);
        if (hdiff[31])
        begin
            hclamp = '0;
        end
        else if (hdiff > thc_pkg::THC_HUM_CLAMP_MAX)
        begin
            hclamp = thc_pkg::THC_HUM_CLAMP_MAX;
        end
        else
        begin
            hclamp = hdiff;
        end
        hum_next = hclamp[28:12];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[9:1], accept};
        end
    end

    always_ff @(posedge clk)
    begin
        p1_reg    <= p1_next;
        dd_reg    <= dd_next;
        rh_reg[1] <= raw_humidity;

        v1_reg    <= v1_next;
        p2_reg    <= p2_next;
        rh_reg[2] <= rh_reg[1];

        fine_reg  <= fine_next;
        rh_reg[3] <= rh_reg[2];

        mh5_reg   <= mh5_next;
        mh6_reg   <= mh6_next;
        mh3_reg   <= mh3_next;
        rh_reg[4] <= rh_reg[3];
        tp_reg[4] <= '{fine: fine_reg, tc: tc_full[23:0], tw: '0, tr: '0};

        a5_reg    <= a5_next;
        bc_reg    <= bc_next;
        mag5_reg  <= tc_mag;
        neg5_reg  <= tp_reg[4].tc[23];
        q5_reg    <= q5_next;
        tp_reg[5] <= tp_reg[4];

        a6_reg    <= a5_reg;
        me_reg    <= me_next;
        tp_reg[6] <= '{fine: tp_reg[5].fine, tc: tp_reg[5].tc, tw: tw_next, tr: tr_next};

        xx7_reg   <= xx7_next;
        tp_reg[7] <= tp_reg[6];

        xx8_reg   <= xx7_reg;
        ss_reg    <= ss_next;
        tp_reg[8] <= tp_reg[7];

        xx9_reg   <= xx8_reg;
        gm_reg    <= gm_next;
        tp_reg[9] <= tp_reg[8];

        hum_reg                <= hum_next;
        fine_temperature       <= tp_reg[9].fine;
        temperature_centi      <= tp_reg[9].tc;
        temperature_whole      <= tp_reg[9].tw;
        temperature_hundredths <= tp_reg[9].tr;
    end

    assign done              = vld_reg[10];
    assign humidity_q10      = hum_reg;
    assign humidity_whole    = hum_reg[16:10];
    assign humidity_fraction = hum_reg[9:0];

    logic signed [31:0] temp_recombined;

    assign temp_recombined = 32'(temperature_whole) * 32'sd100 + 32'(temperature_hundredths);

    // every accepted item leaves the pipeline with done high
    `ASSERT_NXT(a_latency, clk, rst_n, accept, ##9 done)
    // clamp keeps humidity within 0..100 percent
    `ASSERT_IMP(a_hum_range, clk, rst_n, done, (humidity_q10 <= 17'd102400))
    // whole and hundredths recombine to the centi-degree value
    `ASSERT_IMP(a_temp_split, clk, rst_n, done, (temp_recombined == 32'(temperature_centi)))

endmodule

`default_nettype wire
